/* sv/tahu_pkg.sv */
// ----------------------------------------------------------------------------
// tahu_pkg
// Widths, stage indexes, types and the arctangent table of the tilt and
// heading angles unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tahu_pkg;

  localparam int SAMPLE_WIDTH     = 16;
  localparam int ANGLE_ITERATIONS = 16;

  localparam int MAX_ITER  = 24;
  localparam int NUM_ITER  = (ANGLE_ITERATIONS < MAX_ITER) ? ANGLE_ITERATIONS : MAX_ITER;
  localparam int PRE_SHIFT = 8;
  localparam int ANG_FRAC  = 12;

  localparam int SQ_W     = 2 * SAMPLE_WIDTH;
  localparam int RAD_W    = SQ_W + 16;
  localparam int ROOT_W   = SAMPLE_WIDTH + 8;
  localparam int CORDIC_W = SAMPLE_WIDTH + PRE_SHIFT + 3;
  localparam int ANGLE_W  = 29;

  localparam int PITCH_W = 15;
  localparam int ROLL_W  = 16;
  localparam int YAW_W   = 16;

  localparam int ST_SQ0     = 2;
  localparam int ST_ROT     = ST_SQ0 + ROOT_W + 1;
  localparam int ST_OUT     = ST_ROT + NUM_ITER + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  localparam logic signed [ANGLE_W-1:0] Z_QUARTER  = ANGLE_W'(9000 * (1 << ANG_FRAC));
  localparam logic signed [ANGLE_W-1:0] ROUND_HALF = ANGLE_W'(1 << (ANG_FRAC - 1));
  localparam logic signed [ANGLE_W-1:0] PITCH_MAX  = ANGLE_W'(9000);
  localparam logic signed [ANGLE_W-1:0] ROLL_MAX   = ANGLE_W'(18000);
  localparam logic signed [ANGLE_W-1:0] FULL_TURN  = ANGLE_W'(36000);

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] ax;
    logic signed [SAMPLE_WIDTH-1:0] ay;
    logic signed [SAMPLE_WIDTH-1:0] az;
    logic signed [SAMPLE_WIDTH-1:0] mx;
    logic signed [SAMPLE_WIDTH-1:0] my;
  } samp_t;

  typedef struct packed {
    logic                       zero;
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [ANGLE_W-1:0]  z;
  } vec_t;

  // atan(2^-i) in 1/4096 centidegree
  function automatic logic signed [ANGLE_W-1:0] atan_step(input int unsigned idx);
    logic signed [ANGLE_W-1:0] val;
    case (idx)
      0:       val = ANGLE_W'(18432000);
      1:       val = ANGLE_W'(10881045);
      2:       val = ANGLE_W'(5749245);
      3:       val = ANGLE_W'(2918407);
      4:       val = ANGLE_W'(1464867);
      5:       val = ANGLE_W'(733147);
      6:       val = ANGLE_W'(366663);
      7:       val = ANGLE_W'(183343);
      8:       val = ANGLE_W'(91673);
      9:       val = ANGLE_W'(45837);
      10:      val = ANGLE_W'(22918);
      11:      val = ANGLE_W'(11459);
      12:      val = ANGLE_W'(5730);
      13:      val = ANGLE_W'(2865);
      14:      val = ANGLE_W'(1432);
      15:      val = ANGLE_W'(716);
      16:      val = ANGLE_W'(358);
      17:      val = ANGLE_W'(179);
      18:      val = ANGLE_W'(90);
      19:      val = ANGLE_W'(45);
      20:      val = ANGLE_W'(22);
      21:      val = ANGLE_W'(11);
      22:      val = ANGLE_W'(6);
      23:      val = ANGLE_W'(3);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

/* sv/tahu_in_if.sv */
// ----------------------------------------------------------------------------
// tahu_in_if
// Sample request channel: accelerometer and magnetometer axes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tahu_in_if;
  import tahu_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] accel_x;
  logic signed [SAMPLE_WIDTH-1:0] accel_y;
  logic signed [SAMPLE_WIDTH-1:0] accel_z;
  logic signed [SAMPLE_WIDTH-1:0] mag_x;
  logic signed [SAMPLE_WIDTH-1:0] mag_y;

  modport source (output valid, accel_x, accel_y, accel_z, mag_x, mag_y, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, mag_x, mag_y, output ready);
endinterface

`default_nettype wire

/* sv/tahu_out_if.sv */
// ----------------------------------------------------------------------------
// tahu_out_if
// Angle result channel: pitch, roll and heading in centidegrees.
// ----------------------------------------------------------------------------
`default_nettype none

interface tahu_out_if;
  import tahu_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [PITCH_W-1:0] pitch_cdeg;
  logic signed [ROLL_W-1:0]  roll_cdeg;
  logic        [YAW_W-1:0]   yaw_cdeg;

  modport source (output valid, pitch_cdeg, roll_cdeg, yaw_cdeg, input ready);
  modport sink   (input valid, pitch_cdeg, roll_cdeg, yaw_cdeg, output ready);
endinterface

`default_nettype wire

/* sv/tilt_and_heading_angles_unit.sv */
// ----------------------------------------------------------------------------
// tilt_and_heading_angles_unit
// Throughput: one request per cycle unless every stage is full and angles.ready
// is low; any stage holding a bubble still advances.
// Depth is set by the one-bit-per-stage square root and one rotation per stage.
// Reset clears the stage valid bits only; the datapath needs no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_and_heading_angles_unit (
  input  logic       clk,
  input  logic       rst,
  tahu_in_if.sink    samples,
  tahu_out_if.source angles
);
  import tahu_pkg::*;

  function automatic vec_t pre_rotate(input logic signed [CORDIC_W-1:0] y,
                                      input logic signed [CORDIC_W-1:0] x);
    vec_t r;
    r.zero = (x == '0) && (y == '0);
    r.x    = x;
    r.y    = y;
    r.z    = '0;
    if (x < 0) begin
      if (y >= 0) begin
        r.x = y;
        r.y = -x;
        r.z = Z_QUARTER;
      end else begin
        r.x = -y;
        r.y = x;
        r.z = -Z_QUARTER;
      end
    end
    return r;
  endfunction

  function automatic vec_t cordic_iter(input vec_t v, input int unsigned i);
    vec_t                       r;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    dx = v.y >>> i;
    dy = v.x >>> i;
    r  = v;
    if (v.y > 0) begin
      r.x = v.x + dx;
      r.y = v.y - dy;
      r.z = v.z + atan_step(i);
    end else begin
      r.x = v.x - dx;
      r.y = v.y + dy;
      r.z = v.z - atan_step(i);
    end
    return r;
  endfunction

  function automatic logic signed [ANGLE_W-1:0] round_angle(input vec_t v);
    logic signed [ANGLE_W-1:0] zr;
    zr = (v.z + ROUND_HALF) >>> ANG_FRAC;
    if (v.zero) begin
      zr = '0;
    end
    return zr;
  endfunction

  // stage handshake
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] adv;
  logic [NUM_STAGES-1:0] vld_in;

  assign vld_in = {vld[NUM_STAGES-2:0], samples.valid};

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_adv
    assign adv[k] = angles.ready || !(&vld[NUM_STAGES-1:k]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  assign samples.ready = adv[0];
  assign angles.valid  = vld[ST_OUT];

  // sample carry line
  samp_t smp [0:ST_ROT-1];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      smp[0] <= '{ax: samples.accel_x, ay: samples.accel_y, az: samples.accel_z,
                  mx: samples.mag_x, my: samples.mag_y};
    end
    for (int k = 1; k < ST_ROT; k++) begin
      if (adv[k]) begin
        smp[k] <= smp[k-1];
      end
    end
  end

  // squares
  logic signed [SQ_W-1:0] yy_full;
  logic signed [SQ_W-1:0] zz_full;
  logic        [SQ_W-1:0] p_yy;
  logic        [SQ_W-1:0] p_zz;
  logic        [SQ_W-1:0] sq_sum;

  assign yy_full = SQ_W'(smp[0].ay) * SQ_W'(smp[0].ay);
  assign zz_full = SQ_W'(smp[0].az) * SQ_W'(smp[0].az);
  assign sq_sum  = p_yy + p_zz;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      p_yy <= $unsigned(yy_full);
      p_zz <= $unsigned(zz_full);
    end
  end

  // square root, one result bit per stage
  logic [RAD_W-1:0] sq_n [0:ROOT_W-1];
  logic [RAD_W-1:0] sq_r [1:ROOT_W];

  always_ff @(posedge clk) begin
    if (adv[ST_SQ0]) begin
      sq_n[0] <= {sq_sum, {(RAD_W - SQ_W){1'b0}}};
    end
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_root
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (ROOT_W - 1 - j));
    logic [RAD_W-1:0] res_in;
    logic [RAD_W-1:0] trial;
    logic [RAD_W-1:0] n_next;
    logic [RAD_W-1:0] r_next;

    if (j == 0) begin : g_first
      assign res_in = '0;
    end else begin : g_rest
      assign res_in = sq_r[j];
    end

    always_comb begin
      trial = res_in + BIT;
      if (sq_n[j] >= trial) begin
        n_next = sq_n[j] - trial;
        r_next = (res_in >> 1) + BIT;
      end else begin
        n_next = sq_n[j];
        r_next = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[ST_SQ0+j+1]) begin
        sq_r[j+1] <= r_next;
      end
    end

    if (j < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv[ST_SQ0+j+1]) begin
          sq_n[j+1] <= n_next;
        end
      end
    end else begin : g_last
      logic unused_rem;
      assign unused_rem = ^n_next;
    end
  end

  // operands and quadrant turn
  logic signed [CORDIC_W-1:0] ext_ax;
  logic signed [CORDIC_W-1:0] pitch_y;
  logic signed [CORDIC_W-1:0] pitch_x;
  logic signed [CORDIC_W-1:0] roll_y;
  logic signed [CORDIC_W-1:0] roll_x;
  logic signed [CORDIC_W-1:0] yaw_y;
  logic signed [CORDIC_W-1:0] yaw_x;

  always_comb begin
    ext_ax  = CORDIC_W'(smp[ST_ROT-1].ax);
    pitch_y = (-ext_ax) <<< PRE_SHIFT;
    pitch_x = CORDIC_W'(sq_r[ROOT_W][ROOT_W-1:0]);
    roll_y  = CORDIC_W'(smp[ST_ROT-1].ay) <<< PRE_SHIFT;
    roll_x  = CORDIC_W'(smp[ST_ROT-1].az) <<< PRE_SHIFT;
    yaw_y   = CORDIC_W'(smp[ST_ROT-1].my) <<< PRE_SHIFT;
    yaw_x   = CORDIC_W'(smp[ST_ROT-1].mx) <<< PRE_SHIFT;
  end

  logic unused_root;
  assign unused_root = ^sq_r[ROOT_W][RAD_W-1:ROOT_W];

  // rotation stages
  vec_t cp [0:NUM_ITER];
  vec_t cr [0:NUM_ITER];
  vec_t cy [0:NUM_ITER];

  always_ff @(posedge clk) begin
    if (adv[ST_ROT]) begin
      cp[0] <= pre_rotate(pitch_y, pitch_x);
      cr[0] <= pre_rotate(roll_y, roll_x);
      cy[0] <= pre_rotate(yaw_y, yaw_x);
    end
  end

  for (genvar i = 0; i < NUM_ITER; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (adv[ST_ROT+i+1]) begin
        cp[i+1] <= cordic_iter(cp[i], i);
        cr[i+1] <= cordic_iter(cr[i], i);
        cy[i+1] <= cordic_iter(cy[i], i);
      end
    end
  end

  // rounding, limits and output register
  logic signed [ANGLE_W-1:0] pitch_r;
  logic signed [ANGLE_W-1:0] roll_r;
  logic signed [ANGLE_W-1:0] yaw_r;
  logic signed [ANGLE_W-1:0] pitch_next;
  logic signed [ANGLE_W-1:0] roll_next;
  logic signed [ANGLE_W-1:0] yaw_next;
  logic signed [PITCH_W-1:0] pitch_q;
  logic signed [ROLL_W-1:0]  roll_q;
  logic        [YAW_W-1:0]   yaw_q;

  always_comb begin
    pitch_r = round_angle(cp[NUM_ITER]);
    roll_r  = round_angle(cr[NUM_ITER]);
    yaw_r   = round_angle(cy[NUM_ITER]);

    pitch_next = pitch_r;
    if (pitch_r > PITCH_MAX) begin
      pitch_next = PITCH_MAX;
    end else if (pitch_r < -PITCH_MAX) begin
      pitch_next = -PITCH_MAX;
    end

    roll_next = roll_r;
    if (roll_r > ROLL_MAX) begin
      roll_next = ROLL_MAX;
    end else if (roll_r < -ROLL_MAX) begin
      roll_next = -ROLL_MAX;
    end

    yaw_next = yaw_r;
    if (yaw_r < 0) begin
      yaw_next = yaw_r + FULL_TURN;
    end else if (yaw_r >= FULL_TURN) begin
      yaw_next = yaw_r - FULL_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      pitch_q <= PITCH_W'(pitch_next);
      roll_q  <= ROLL_W'(roll_next);
      yaw_q   <= YAW_W'(yaw_next);
    end
  end

  assign angles.pitch_cdeg = pitch_q;
  assign angles.roll_cdeg  = roll_q;
  assign angles.yaw_cdeg   = yaw_q;

  // checks
  a_accept_fills_first: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> vld[0])
    else $error("accepted request did not enter the first stage");

  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    !samples.ready |-> (&vld) && !angles.ready)
    else $error("request refused while the pipeline has a bubble");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    angles.valid |-> angles.yaw_cdeg < YAW_W'(36000))
    else $error("heading out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    angles.valid |-> angles.pitch_cdeg <= PITCH_W'(9000) &&
                     angles.pitch_cdeg >= -PITCH_W'(9000))
    else $error("pitch out of range");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    angles.valid |-> angles.roll_cdeg <= ROLL_W'(18000) &&
                     angles.roll_cdeg >= -ROLL_W'(18000))
    else $error("roll out of range");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tilt and heading angles unit. Sensor samples
// (directed corners, then weighted random axes) go in through a valid/ready
// driver; an in-bench CORDIC predictor computes pitch, roll and heading for
// every accepted request, and the monitor checks each result in order.
// Both sides idle at random, the receiver holds off once for a long stretch
// and the sender pauses until the pipeline has drained.
// ----------------------------------------------------------------------------

module tb_top;
  import tahu_pkg::*;

  localparam int      SW          = SAMPLE_WIDTH;
  localparam int      ROT_STEPS   = (ANGLE_ITERATIONS < 24) ? ANGLE_ITERATIONS : 24;
  localparam int      FRAC_BITS   = 12;
  localparam longint  QUARTER_Z   = longint'(9000) <<< FRAC_BITS;
  localparam longint  HALF_LSB    = longint'(1) <<< (FRAC_BITS - 1);
  localparam int      DRAIN_WAIT  = 120;
  localparam int      LONG_HOLD   = 400;

  localparam logic signed [SW-1:0] AXIS_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] AXIS_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct packed {
    logic signed [PITCH_W-1:0] pitch;
    logic signed [ROLL_W-1:0]  roll;
    logic        [YAW_W-1:0]   yaw;
  } angles_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tahu_in_if  samples_if ();
  tahu_out_if angles_if ();

  tilt_and_heading_angles_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .angles  (angles_if)
  );

  always #10 clk = ~clk;

  samp_t   pending_samples[$];
  angles_t expected_angles[$];
  int      mismatches = 0;

  logic    in_acc  = 1'b0;
  logic    out_acc = 1'b0;
  bit      tx_steady = 1'b0;
  bit      rx_steady = 1'b0;
  bit      rx_hold_req = 1'b0;
  int      tx_wait = 0;
  int      rx_wait = 0;
  int      rx_hold_left = 0;

  // atan(2^-i) in 1/4096 centidegree
  function automatic longint atan_step_z(int idx);
    case (idx)
      0:  return 18432000;
      1:  return 10881045;
      2:  return 5749245;
      3:  return 2918407;
      4:  return 1464867;
      5:  return 733147;
      6:  return 366663;
      7:  return 183343;
      8:  return 91673;
      9:  return 45837;
      10: return 22918;
      11: return 11459;
      12: return 5730;
      13: return 2865;
      14: return 1432;
      15: return 716;
      16: return 358;
      17: return 179;
      18: return 90;
      19: return 45;
      20: return 22;
      21: return 11;
      22: return 6;
      23: return 3;
      default: return 0;
    endcase
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned probe;
    res   = 0;
    probe = 64'd1 << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= res + probe) begin
        n   = n - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // vectoring cordic, centidegrees rounded half up
  function automatic longint cordic_angle(longint y, longint x);
    longint z;
    longint t;
    longint dx;
    longint dy;
    int     k;
    if (x == 0 && y == 0) return 0;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t;
        z = QUARTER_Z;
      end else begin
        t = x; x = -y; y = t;
        z = -QUARTER_Z;
      end
    end
    for (k = 0; k < ROT_STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + atan_step_z(k);
      end else begin
        x = x - dx; y = y + dy; z = z - atan_step_z(k);
      end
    end
    return (z + HALF_LSB) >>> FRAC_BITS;
  endfunction

  function automatic angles_t predict_angles(samp_t s);
    longint  ax, ay, az, mx, my;
    longint  radius, pitch, roll, yaw;
    angles_t a;
    ax = longint'(s.ax);
    ay = longint'(s.ay);
    az = longint'(s.az);
    mx = longint'(s.mx);
    my = longint'(s.my);
    radius = longint'(int_sqrt(64'(ay * ay + az * az) << 16));
    pitch  = cordic_angle(-ax * 256, radius);
    roll   = cordic_angle(ay * 256, az * 256);
    yaw    = cordic_angle(my * 256, mx * 256);
    if (pitch > 9000)   pitch = 9000;
    if (pitch < -9000)  pitch = -9000;
    if (roll > 18000)   roll = 18000;
    if (roll < -18000)  roll = -18000;
    if (yaw < 0)        yaw = yaw + 36000;
    if (yaw >= 36000)   yaw = yaw - 36000;
    a.pitch = PITCH_W'(pitch);
    a.roll  = ROLL_W'(roll);
    a.yaw   = YAW_W'(yaw);
    return a;
  endfunction

  function automatic logic signed [SW-1:0] pick_axis();
    logic signed [SW-1:0] v;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: v = SW'($urandom);
      4:          v = SW'(int'($urandom_range(0, 32)) - 16);
      5: begin
        case ($urandom_range(0, 4))
          0:       v = AXIS_MIN;
          1:       v = AXIS_MAX;
          2:       v = '0;
          3:       v = '1;
          default: v = SW'(1);
        endcase
      end
      6: begin
        v = SW'($urandom);
        v = v >>> $urandom_range(1, SW - 2);
      end
      default: v = AXIS_MIN + SW'($urandom_range(0, 15));
    endcase
    return v;
  endfunction

  function automatic samp_t random_sample();
    samp_t s;
    s.ax = pick_axis();
    s.ay = pick_axis();
    s.az = pick_axis();
    s.mx = pick_axis();
    s.my = pick_axis();
    case ($urandom_range(0, 15))
      0: begin s.ay = '0; s.az = '0; end
      1: begin s.mx = '0; s.my = '0; end
      2: begin s.ax = '0; s.ay = '0; s.az = '0; end
      3: s.my = '0;
      default: ;
    endcase
    return s;
  endfunction

  function automatic int draw_wait(bit steady);
    if (steady) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic push_sample(input logic signed [SW-1:0] ax, ay, az, mx, my);
    samp_t s;
    s.ax = ax; s.ay = ay; s.az = az; s.mx = mx; s.my = my;
    pending_samples.push_back(s);
  endtask

  task automatic push_random(input int count);
    for (int n = 0; n < count; n++) pending_samples.push_back(random_sample());
  endtask

  task automatic wait_pipeline_empty();
    while (pending_samples.size() > 0 || samples_if.valid === 1'b1 ||
           expected_angles.size() > 0)
      @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst) begin
      if (in_acc || samples_if.valid !== 1'b1) begin
        if (tx_wait > 0) begin
          tx_wait--;
          samples_if.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          samp_t s;
          s = pending_samples.pop_front();
          samples_if.accel_x <= s.ax;
          samples_if.accel_y <= s.ay;
          samples_if.accel_z <= s.az;
          samples_if.mag_x   <= s.mx;
          samples_if.mag_y   <= s.my;
          samples_if.valid   <= 1'b1;
          tx_wait = draw_wait(tx_steady);
        end else begin
          samples_if.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst) begin
      if (out_acc) rx_wait = draw_wait(rx_steady);
      if (rx_hold_req) begin
        rx_hold_left = LONG_HOLD;
        rx_hold_req  = 1'b0;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        angles_if.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        angles_if.ready <= 1'b0;
      end else begin
        angles_if.ready <= 1'b1;
      end
    end
  end

  // predictor and checker
  always @(posedge clk) begin
    if (rst) begin
      in_acc  <= 1'b0;
      out_acc <= 1'b0;
    end else begin
      samp_t   s;
      angles_t want;
      in_acc  <= samples_if.valid && samples_if.ready;
      out_acc <= angles_if.valid && angles_if.ready;
      if (samples_if.valid && samples_if.ready) begin
        s.ax = samples_if.accel_x;
        s.ay = samples_if.accel_y;
        s.az = samples_if.accel_z;
        s.mx = samples_if.mag_x;
        s.my = samples_if.mag_y;
        expected_angles.push_back(predict_angles(s));
      end
      if (angles_if.valid && angles_if.ready) begin
        if (expected_angles.size() == 0) begin
          $error("unexpected result: pitch %0d roll %0d yaw %0d",
                 angles_if.pitch_cdeg, angles_if.roll_cdeg, angles_if.yaw_cdeg);
          mismatches++;
        end else begin
          want = expected_angles.pop_front();
          if (angles_if.pitch_cdeg !== want.pitch) begin
            $error("pitch_cdeg: expected %0d, actual %0d", want.pitch, angles_if.pitch_cdeg);
            mismatches++;
          end
          if (angles_if.roll_cdeg !== want.roll) begin
            $error("roll_cdeg: expected %0d, actual %0d", want.roll, angles_if.roll_cdeg);
            mismatches++;
          end
          if (angles_if.yaw_cdeg !== want.yaw) begin
            $error("yaw_cdeg: expected %0d, actual %0d", want.yaw, angles_if.yaw_cdeg);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    samples_if.valid   = 1'b0;
    samples_if.accel_x = '0;
    samples_if.accel_y = '0;
    samples_if.accel_z = '0;
    samples_if.mag_x   = '0;
    samples_if.mag_y   = '0;
    angles_if.ready    = 1'b0;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // corners: zero vectors, full scale, vertical tilt, quadrant turns, heading wrap
    push_sample('0, '0, '0, '0, '0);
    push_sample(AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX);
    push_sample(AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN);
    push_sample(AXIS_MIN, '0, '0, AXIS_MIN, '0);
    push_sample(AXIS_MAX, '0, '0, AXIS_MIN, '1);
    push_sample('0, '0, AXIS_MIN, AXIS_MAX, '1);
    push_sample('0, '1, AXIS_MIN, '0, AXIS_MAX);
    push_sample('0, AXIS_MAX, '0, '0, AXIS_MIN);
    push_sample('0, AXIS_MIN, '0, SW'(1), '0);
    push_sample(SW'(1), '0, SW'(1), '1, '1);
    push_sample('1, SW'(1), '0, '1, SW'(1));
    push_sample(AXIS_MAX, AXIS_MIN, AXIS_MIN, '1, '0);
    push_sample(AXIS_MIN, AXIS_MAX, AXIS_MAX, '0, '1);
    push_sample(AXIS_MAX, AXIS_MAX, AXIS_MIN, AXIS_MAX, AXIS_MIN);
    push_sample(AXIS_MIN, AXIS_MIN, AXIS_MAX, AXIS_MIN, AXIS_MAX);
    push_sample('0, AXIS_MIN, AXIS_MIN, AXIS_MAX, SW'(1));
    push_sample('1, '1, '1, SW'(1), '1);
    push_sample(SW'(100), SW'(-200), SW'(300), SW'(-400), SW'(500));
    push_sample(AXIS_MAX, '0, SW'(1), SW'(-3), SW'(-4));
    push_sample('0, '0, '0, '0, AXIS_MIN);
    wait_pipeline_empty();

    push_random(600);
    wait_pipeline_empty();

    // sender streams while the receiver holds off, backing up the pipeline
    tx_steady   = 1'b1;
    rx_steady   = 1'b0;
    push_random(400);
    rx_hold_req = 1'b1;
    while (pending_samples.size() > 0) @(posedge clk);

    tx_steady = 1'b0;
    rx_steady = 1'b1;
    push_random(400);
    while (pending_samples.size() > 0) @(posedge clk);

    tx_steady = 1'b1;
    push_random(200);
    while (pending_samples.size() > 0) @(posedge clk);

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    push_random(300);
    wait_pipeline_empty();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* sim.f */
sv/tahu_pkg.sv
sv/tahu_in_if.sv
sv/tahu_out_if.sv
sv/tilt_and_heading_angles_unit.sv
tb/tb_top.sv
